[rtl/sorted_insert_stack_top_defines.svh]
// assertion macros shared by the sorted insert stack modules
// no dependencies; included inside module bodies
`ifndef SORTED_INSERT_STACK_TOP_DEFINES_SVH
`define SORTED_INSERT_STACK_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define SIS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("sorted insert stack: same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define SIS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("sorted insert stack: next-cycle check failed");

`endif

[rtl/sis_pkg.sv]
// shared types and constants of the sorted insert stack
// no dependencies
package sis_pkg;

	localparam int DEPTH   = 16;
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int IDX_W   = $clog2(DEPTH);
	localparam int DATA_W  = 32;
	localparam int COUNT_W = 5;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_POP    = 2'd1,
		OP_PEEK   = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_OVERFLOW = 2'd1,
		ST_EMPTY    = 2'd2
	} status_t;

	localparam logic signed [DATA_W-1:0] EMPTY_VALUE = -'sd1;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;  // capture the request payload
		logic exec;  // apply the captured operation and register the result
	} cmd_t;

endpackage

[rtl/sis_req_if.sv]
// request channel: operation and value, valid/ready handshake
// depends on sis_pkg
interface sis_req_if;
	logic                              valid;
	logic                              ready;
	logic [1:0]                        op;
	logic signed [sis_pkg::DATA_W-1:0] value;

	modport source (output valid, output op, output value, input ready);
	modport sink (input valid, input op, input value, output ready);
endinterface

[rtl/sis_rsp_if.sv]
// response channel: result value, status and count, valid/ready handshake
// depends on sis_pkg
interface sis_rsp_if;
	logic                               valid;
	logic                               ready;
	logic signed [sis_pkg::DATA_W-1:0]  value_res;
	logic [1:0]                         status;
	logic [sis_pkg::COUNT_W-1:0]        count;

	modport source (output valid, output value_res, output status, output count, input ready);
	modport sink (input valid, input value_res, input status, input count, output ready);
endinterface

[rtl/sis_ctrl.sv]
// controller state machine of the sorted insert stack
// depends on sis_pkg and sorted_insert_stack_top_defines.svh
module sis_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output sis_pkg::cmd_t  cmd
);
	import sis_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   req_xfer;
	logic   rsp_xfer;

	assign rsp_xfer  = out_valid_q & rsp_ready;
	assign req_ready = (state_q == S_IDLE) & (~out_valid_q | rsp_ready);
	assign req_xfer  = req_valid & req_ready;

	assign cmd.load = req_xfer;
	assign cmd.exec = (state_q == S_EXEC);
	assign rsp_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_xfer) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.exec) begin
			out_valid_q <= 1'b1;
		end else if (rsp_xfer) begin
			out_valid_q <= 1'b0;
		end
	end

`include "sorted_insert_stack_top_defines.svh"

	// the result register is always free when the update cycle loads it
	`SIS_ASSERT_NOW(a_exec_out_free, clk, arst_n, state_q == S_EXEC, !out_valid_q)
	// an accepted request is executed in the following cycle
	`SIS_ASSERT_NEXT(a_xfer_exec, clk, arst_n, req_xfer, state_q == S_EXEC)
	// the update cycle always leaves a result pending
	`SIS_ASSERT_NEXT(a_exec_result, clk, arst_n, state_q == S_EXEC, out_valid_q)

endmodule

[rtl/sis_datapath.sv]
// datapath of the sorted insert stack: sorted cell row, fill count, result register
// depends on sis_pkg and sorted_insert_stack_top_defines.svh
module sis_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  sis_pkg::cmd_t                     cmd,
	input  logic [1:0]                        op,
	input  logic signed [sis_pkg::DATA_W-1:0] value,
	output logic signed [sis_pkg::DATA_W-1:0] value_res,
	output logic [1:0]                        status,
	output logic [sis_pkg::COUNT_W-1:0]       count
);
	import sis_pkg::*;

	logic signed [DATA_W-1:0] entries_q [DEPTH];
	logic [CNT_W-1:0]         fill_q;
	op_t                      op_q;
	logic signed [DATA_W-1:0] value_q;

	logic signed [DATA_W-1:0] res_value_q;
	status_t                  res_status_q;
	logic [COUNT_W-1:0]       res_count_q;

	logic                     full;
	logic                     empty;
	logic [CNT_W-1:0]         fill_dec;
	logic [IDX_W-1:0]         top_idx;
	logic signed [DATA_W-1:0] top;
	logic [CNT_W-1:0]         eff_fill;
	logic [DEPTH-1:0]         ge;
	logic                     do_insert;
	logic [CNT_W-1:0]         fill_nxt;
	logic signed [DATA_W-1:0] res_value_nxt;
	status_t                  res_status_nxt;

	assign full     = (fill_q == CNT_W'(DEPTH));
	assign empty    = (fill_q == '0);
	assign fill_dec = fill_q - CNT_W'(1);
	assign top_idx  = fill_dec[IDX_W-1:0];
	assign top      = entries_q[top_idx];
	// when full and inserting, the top is dropped first
	assign eff_fill = full ? CNT_W'(DEPTH - 1) : fill_q;

	// per-cell compare: stored value at or above the new one
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			ge[i] = (CNT_W'(i) < eff_fill) && (entries_q[i] >= value_q);
		end
	end

	always_comb begin
		do_insert      = 1'b0;
		fill_nxt       = fill_q;
		res_value_nxt  = '0;
		res_status_nxt = ST_OK;
		case (op_q)
			OP_INSERT: begin
				if (full) begin
					res_status_nxt = ST_OVERFLOW;
					do_insert      = (value_q <= top);
				end else begin
					do_insert = 1'b1;
					fill_nxt  = fill_q + CNT_W'(1);
				end
			end
			OP_POP, OP_PEEK: begin
				if (empty) begin
					res_value_nxt  = EMPTY_VALUE;
					res_status_nxt = ST_EMPTY;
				end else begin
					res_value_nxt = top;
					if (op_q == OP_POP) begin
						fill_nxt = fill_dec;
					end
				end
			end
			default: begin
				fill_nxt = fill_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= op_t'(op);
			value_q <= value;
		end
	end

	// cell row: shift up above the insertion point, new value at it
	always_ff @(posedge clk) begin
		if (cmd.exec && do_insert) begin
			for (int i = 0; i < DEPTH; i++) begin
				if (i > 0 && ge[(i > 0) ? i - 1 : 0]) begin
					entries_q[i] <= entries_q[(i > 0) ? i - 1 : 0];
				end else if (ge[i] || CNT_W'(i) == eff_fill) begin
					entries_q[i] <= value_q;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (cmd.exec) begin
			fill_q <= fill_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			res_value_q  <= res_value_nxt;
			res_status_q <= res_status_nxt;
			res_count_q  <= COUNT_W'(fill_nxt);
		end
	end

	assign value_res = res_value_q;
	assign status    = res_status_q;
	assign count     = res_count_q;

`include "sorted_insert_stack_top_defines.svh"

	`SIS_ASSERT_NOW(a_fill_bound, clk, arst_n, 1'b1, fill_q <= CNT_W'(DEPTH))
	`SIS_ASSERT_NEXT(a_pop_dec, clk, arst_n, cmd.exec && op_q == OP_POP && !empty, fill_q == CNT_W'($past(fill_q) - CNT_W'(1)))
	`SIS_ASSERT_NEXT(a_ins_inc, clk, arst_n, cmd.exec && op_q == OP_INSERT && !full, fill_q == CNT_W'($past(fill_q) + CNT_W'(1)))

endmodule

[rtl/sorted_insert_stack_top.sv]
// top level of the sorted insert stack: controller plus datapath
// depends on sis_pkg, sis_req_if, sis_rsp_if, sis_ctrl, sis_datapath
//
//  channel | dir | payload                         | handshake
//  --------+-----+---------------------------------+-------------
//  req     | in  | op[1:0], value[31:0]            | valid/ready
//  rsp     | out | value_res[31:0], status, count  | valid/ready
//
// each item has a capture step, then an update step in which
// the 16 cells compare against the new value in parallel and shift in one step
// the result sits in an output register; a request is taken only while that
// register is empty or its transfer happens in the same cycle, so a stalled
// response holds off the request side; no request is taken during an update
// reset clears the fill count and the controller; cells above the fill count are never read
module sorted_insert_stack_top (
	input  logic      clk,
	input  logic      arst_n,
	sis_req_if.sink   req,
	sis_rsp_if.source rsp
);
	import sis_pkg::*;

	// command bundle from the controller to the datapath
	cmd_t cmd;

	// controller: sequences capture and update, owns both handshakes
	sis_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd)
	);

	// datapath: sorted cell row, fill count and result register
	sis_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.op        (req.op),
		.value     (req.value),
		.value_res (rsp.value_res),
		.status    (rsp.status),
		.count     (rsp.count)
	);

endmodule
